@@ rtl/odd_pkg.sv @@
// Shared types and constants for the occupancy disk dilation unit.
package odd_pkg;

  // Fixed field widths
  localparam int COORD_W = 7;
  localparam int VAL_W   = 8;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 2;

  // Cell value that marks an obstacle
  localparam logic [VAL_W-1:0] OBSTACLE = VAL_W'(1);

  // Command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS     = 2'd0,
    REG_MAP_WIDTH  = 2'd1,
    REG_MAP_HEIGHT = 2'd2
  } reg_idx_t;

  // Reset values of the configuration registers
  localparam logic [3:0]       RADIUS_RST = 4'd0;
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(128);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(128);

endpackage

@@ rtl/odd_disk_walk.sv @@
// Offset walker: steps (dx, dy) over the square around a cell and flags disk members.
module odd_disk_walk #(
  parameter int MAX_RADIUS = 8
) (
  input  logic                                     clk,
  input  logic                                     load,
  input  logic                                     step,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]          rad,
  output logic signed [$clog2(MAX_RADIUS+1):0]     dx,
  output logic signed [$clog2(MAX_RADIUS+1):0]     dy,
  output logic                                     last,
  output logic                                     in_disk
);

  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int SQ_W  = 2 * RAD_W + 1;

  logic signed [RAD_W:0] rad_s;
  logic [RAD_W-1:0]      abs_dx;
  logic [RAD_W-1:0]      abs_dy;
  logic [SQ_W-1:0]       dist_sq;
  logic [SQ_W-1:0]       rad_sq;

  assign rad_s = signed'({1'b0, rad});

  // Distance test against the disk
  assign abs_dx  = dx[RAD_W] ? RAD_W'(-dx) : RAD_W'(dx);
  assign abs_dy  = dy[RAD_W] ? RAD_W'(-dy) : RAD_W'(dy);
  assign dist_sq = SQ_W'(abs_dx * abs_dx) + SQ_W'(abs_dy * abs_dy);
  assign rad_sq  = SQ_W'(rad * rad);
  assign in_disk = (dist_sq <= rad_sq);

  assign last = (dx == rad_s) && (dy == rad_s);

  // Raster order: dx fastest, then dy
  always_ff @(posedge clk) begin
    if (load) begin
      dx <= -rad_s;
      dy <= -rad_s;
    end else if (step) begin
      if (dx == rad_s) begin
        dx <= -rad_s;
        dy <= dy + (RAD_W+1)'(1);
      end else begin
        dx <= dx + (RAD_W+1)'(1);
      end
    end
  end

endmodule

@@ rtl/occupancy_disk_dilation_unit.sv @@
// Occupancy map with disk-dilated reads: top level.
// A write gives no result; busy stays low.
// An in-map read holds busy while it walks the square around the cell, reading the map
// memory at each offset in the effective-radius disk that lies in the map, then the cell.
// done pulses in the cycle busy falls; a new command is taken only while busy is low.
// An out-of-map read gives done the cycle after the transfer, without going busy.
// Reset sets radius 0 and a 128 by 128 map; map contents stay undefined until written.
module occupancy_disk_dilation_unit #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 128,
  parameter int MAX_RADIUS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [odd_pkg::COORD_W-1:0]   col,
  input  logic [odd_pkg::COORD_W-1:0]   row,
  input  logic [odd_pkg::VAL_W-1:0]     cell_value,
  output logic                          done,
  output logic [odd_pkg::COORD_W-1:0]   out_col,
  output logic [odd_pkg::COORD_W-1:0]   out_row,
  output logic [odd_pkg::VAL_W-1:0]     inflated_value,
  output logic                          out_of_range,
  input  logic                          cfg_we,
  input  logic [odd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [odd_pkg::CFG_W-1:0]     cfg_data
);

  import odd_pkg::*;

  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int NB_W   = COORD_W + RAD_W + 2;
  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OWN,
    ST_RESP
  } state_t;

  state_t state;

  // Configuration registers
  logic [3:0]       radius;
  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;

  // Current read
  logic [COORD_W-1:0] col_q;
  logic [COORD_W-1:0] row_q;
  logic               hit;
  logic               chk;

  // Map memory
  logic [VAL_W-1:0]  cell_mem [CELLS];
  logic [VAL_W-1:0]  rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // Scan datapath
  logic [RAD_W-1:0]         eff_rad;
  logic signed [RAD_W:0]    dx;
  logic signed [RAD_W:0]    dy;
  logic                     last;
  logic                     in_disk;
  logic                     walk_load;
  logic signed [NB_W-1:0]   nx;
  logic signed [NB_W-1:0]   ny;
  logic                     nb_ok;
  logic [ADDR_W-1:0]        nb_addr;
  logic [ADDR_W-1:0]        own_addr;
  logic                     in_map;
  logic                     accept;
  logic                     rd_hit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RADIUS_RST;
      map_width  <= WIDTH_RST;
      map_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:     radius     <= cfg_data[3:0];
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated radius and map bounds
  assign eff_rad = (32'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);

  assign in_map = (32'(col) < 32'(map_width))  && (32'(col) < MAX_COLS) &&
                  (32'(row) < 32'(map_height)) && (32'(row) < MAX_ROWS);

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign walk_load = accept && (cmd == CMD_READ);

  odd_disk_walk #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_walk (
    .clk     (clk),
    .load    (walk_load),
    .step    (state == ST_SCAN),
    .rad     (eff_rad),
    .dx      (dx),
    .dy      (dy),
    .last    (last),
    .in_disk (in_disk)
  );

  // Neighbor coordinates and bounds check
  assign nx = NB_W'(signed'({1'b0, col_q})) + NB_W'(dx);
  assign ny = NB_W'(signed'({1'b0, row_q})) + NB_W'(dy);

  assign nb_ok = in_disk && !nx[NB_W-1] && !ny[NB_W-1] &&
                 (32'(nx[NB_W-2:0]) < 32'(map_width))  && (32'(nx[NB_W-2:0]) < MAX_COLS) &&
                 (32'(ny[NB_W-2:0]) < 32'(map_height)) && (32'(ny[NB_W-2:0]) < MAX_ROWS);

  assign nb_addr  = ADDR_W'(32'(ny[NB_W-2:0]) * MAX_COLS + 32'(nx[NB_W-2:0]));
  assign own_addr = ADDR_W'(32'(row_q) * MAX_COLS + 32'(col_q));

  // Memory ports
  assign wr_en   = accept && (cmd == CMD_WRITE) && in_map;
  assign wr_addr = ADDR_W'(32'(row) * MAX_COLS + 32'(col));
  assign rd_en   = ((state == ST_SCAN) && nb_ok) || (state == ST_OWN);
  assign rd_addr = (state == ST_OWN) ? own_addr : nb_addr;
  assign rd_hit  = chk && (rdata == OBSTACLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= cell_value;
    end
    if (rd_en) begin
      rdata <= cell_mem[rd_addr];
    end
  end

  // Read sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      hit   <= 1'b0;
      chk   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (walk_load) begin
            col_q   <= col;
            row_q   <= row;
            out_col <= col;
            out_row <= row;
            hit     <= 1'b0;
            chk     <= 1'b0;
            if (in_map) begin
              state <= ST_SCAN;
            end else begin
              done           <= 1'b1;
              out_of_range   <= 1'b1;
              inflated_value <= '0;
            end
          end
        end
        ST_SCAN: begin
          chk <= nb_ok;
          if (rd_hit) hit <= 1'b1;
          if (last) state <= ST_OWN;
        end
        ST_OWN: begin
          // last scan read lands here
          chk <= 1'b0;
          if (rd_hit) hit <= 1'b1;
          state <= ST_RESP;
        end
        ST_RESP: begin
          done           <= 1'b1;
          out_of_range   <= 1'b0;
          inflated_value <= hit ? OBSTACLE : rdata;
          state          <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // In-map results only come out of the response state
  a_resp_origin: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range) |-> $past(state == ST_RESP))
    else $error("in-map result without response state");

  // Out-of-map results carry a zero value
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (inflated_value == '0))
    else $error("out-of-map result with nonzero value");

  // The hit flag is only set by scan read data
  a_hit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(hit) |-> $past(state == ST_SCAN || state == ST_OWN))
    else $error("hit set outside scan");

  // Every memory read is consumed by a later busy cycle
  a_rd_busy: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state != ST_IDLE))
    else $error("memory read with no consumer");

endmodule
